@@ src/efi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_pkg: shared types and constants of the inverse error function unit
// Holds the fixed-point constants of the closed-form approximation with
// a = 0.147, the internal word widths and the per-word side information.
// ----------------------------------------------------------------------------
package efi_pkg;

	// Default fraction widths of the input and output words.
	localparam int IN_FRAC_BITS_DEF  = 30;
	localparam int OUT_FRAC_BITS_DEF = 27;

	// The final square root delivers its result with this many fraction bits.
	localparam int SQRT_FRAC = 29;

	// ln(2), 1/a and 2/(pi*a), all in Q.28.
	localparam logic [27:0]        LN2_Q28   = 28'd186065280;
	localparam logic [30:0]        INV_A_Q28 = 31'd1826091537;
	localparam logic signed [33:0] K_Q28     = 34'sd1162525979;

	// Internal widths.
	localparam int LOG_STEPS = 30;   // squaring steps, one log bit each
	localparam int FRAC_W    = 30;   // fraction bits of the log
	localparam int NL_W      = 37;   // -log2(1-x^2) in Q.30
	localparam int W_W       = 35;   // -ln(1-x^2) in Q.28
	localparam int WA_W      = 36;   // w/a in Q.28
	localparam int T_W       = 34;   // signed t in Q.28
	localparam int TA_W      = 33;   // magnitude of t
	localparam int REM_W     = 34;   // square root remainder
	localparam int ROOT_W    = 32;   // square root result
	localparam int SQRT_IN_W = 64;   // square root radicand

	// Side information that travels with every word.
	typedef struct packed {
		logic neg;    // sign of the argument
		logic zero;   // argument rescales to zero
		logic inf;    // magnitude of one or more
	} meta_t;

	localparam int META_W = $bits(meta_t);

endpackage

@@ src/efi_log2_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_log2_pipe: pipelined binary logarithm of a 64-bit fraction
// Normalizes u in two stages, then squares the mantissa once per stage to
// draw one fraction bit of the log each time, and finally forms
// nl = -log2(u / 2^64) in Q.30.
// ----------------------------------------------------------------------------
module efi_log2_pipe #(
	parameter int SB_W = efi_pkg::META_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [63:0]               in_u,
	input  logic [SB_W-1:0]           in_sb,
	output logic                      out_valid,
	output logic [efi_pkg::NL_W-1:0]  out_nl,
	output logic [SB_W-1:0]           out_sb
);

	localparam int STEPS = efi_pkg::LOG_STEPS;
	localparam int FW    = efi_pkg::FRAC_W;
	localparam int NW    = efi_pkg::NL_W;

	logic [6:0]      lzc_c;
	logic            v_a;
	logic [63:0]     u_a;
	logic [6:0]      lzc_a;
	logic [SB_W-1:0] sb_a;

	logic            v_b;
	logic [31:0]     mm_b;
	logic [6:0]      lzc_b;
	logic [SB_W-1:0] sb_b;

	logic            v_s   [1:STEPS];
	logic [31:0]     mm_s  [1:STEPS];
	logic [FW-1:0]   frac_s[1:STEPS];
	logic [6:0]      lzc_s [1:STEPS];
	logic [SB_W-1:0] sb_s  [1:STEPS];

	logic            v_n;
	logic [NW-1:0]   nl_n;
	logic [SB_W-1:0] sb_n;

	// Leading zero count of the input u.
	always_comb begin
		lzc_c = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (in_u[i]) begin
				lzc_c = 7'(63 - i);
			end
		end
	end

	// Stage A: register the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
		end else if (en) begin
			v_a <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_a   <= in_u;
			lzc_a <= lzc_c;
			sb_a  <= in_sb;
		end
	end

	// Stage B: shift the leading one to bit 31 of the mantissa.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b <= 1'b0;
		end else if (en) begin
			v_b <= v_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mm_b  <= 32'((u_a << lzc_a) >> 32);
			lzc_b <= lzc_a;
			sb_b  <= sb_a;
		end
	end

	// Squaring stages: each square that reaches 2.0 yields a one bit.
	for (genvar k = 0; k < STEPS; k++) begin : g_sq
		logic            p_v;
		logic [31:0]     p_mm;
		logic [FW-1:0]   p_frac;
		logic [6:0]      p_lzc;
		logic [SB_W-1:0] p_sb;
		logic [63:0]     sq;
		logic [32:0]     q;

		if (k == 0) begin : g_first
			assign p_v    = v_b;
			assign p_mm   = mm_b;
			assign p_frac = '0;
			assign p_lzc  = lzc_b;
			assign p_sb   = sb_b;
		end else begin : g_next
			assign p_v    = v_s[k];
			assign p_mm   = mm_s[k];
			assign p_frac = frac_s[k];
			assign p_lzc  = lzc_s[k];
			assign p_sb   = sb_s[k];
		end

		assign sq = {32'd0, p_mm} * {32'd0, p_mm};
		assign q  = sq[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mm_s[k+1]   <= q[32] ? q[32:1] : q[31:0];
				frac_s[k+1] <= {p_frac[FW-2:0], q[32]};
				lzc_s[k+1]  <= p_lzc;
				sb_s[k+1]   <= p_sb;
			end
		end
	end

	// Final stage: integer part from the shift count, minus the fraction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n <= 1'b0;
		end else if (en) begin
			v_n <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_n <= NW'({lzc_s[STEPS] + 7'd1, 30'd0}) - NW'(frac_s[STEPS]);
			sb_n <= sb_s[STEPS];
		end
	end

	assign out_valid = v_n;
	assign out_nl    = nl_n;
	assign out_sb    = sb_n;

endmodule

@@ src/efi_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efi_sqrt_pipe: pipelined integer square root of a 64-bit word
// Restoring digit-by-digit method, one result bit per stage, 32 stages.
// Side information travels alongside unchanged.
// ----------------------------------------------------------------------------
module efi_sqrt_pipe #(
	parameter int SB_W = efi_pkg::META_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [efi_pkg::SQRT_IN_W-1:0] in_x,
	input  logic [SB_W-1:0]               in_sb,
	output logic                          out_valid,
	output logic [efi_pkg::ROOT_W-1:0]    out_root,
	output logic [SB_W-1:0]               out_sb
);

	localparam int STEPS = efi_pkg::ROOT_W;
	localparam int RW    = efi_pkg::REM_W;
	localparam int XW    = efi_pkg::SQRT_IN_W;

	logic            v_s   [1:STEPS];
	logic [RW-1:0]   rem_s [1:STEPS];
	logic [STEPS-1:0] root_s[1:STEPS];
	logic [XW-1:0]   x_s   [1:STEPS];
	logic [SB_W-1:0] sb_s  [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic             p_v;
		logic [RW-1:0]    p_rem;
		logic [STEPS-1:0] p_root;
		logic [XW-1:0]    p_x;
		logic [SB_W-1:0]  p_sb;
		logic [RW+1:0]    cur;
		logic [RW+1:0]    trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign p_v    = in_valid;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_x    = in_x;
			assign p_sb   = in_sb;
		end else begin : g_next
			assign p_v    = v_s[k];
			assign p_rem  = rem_s[k];
			assign p_root = root_s[k];
			assign p_x    = x_s[k];
			assign p_sb   = sb_s[k];
		end

		// Bring down two radicand bits and try the next root bit.
		assign cur   = {p_rem, p_x[XW-1:XW-2]};
		assign trial = (RW+2)'({p_root, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? RW'(cur - trial) : RW'(cur);
				root_s[k+1] <= {p_root[STEPS-2:0], ge};
				x_s[k+1]    <= {p_x[XW-3:0], 2'b00};
				sb_s[k+1]   <= p_sb;
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_root  = root_s[STEPS];
	assign out_sb    = sb_s[STEPS];

endmodule

@@ src/inverse_error_function_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; the path
// is 104 pipeline stages plus the output register, set by the 30 log
// squaring stages and the two 32-stage square root pipelines. A stalled
// output holds the pipeline only while its last stage is full. Reset clears
// the valid bits, the output valid among them; data registers, also the
// output data, keep whatever they hold.
// ----------------------------------------------------------------------------
// inverse_error_function_unit: streaming approximate erfinv
// Takes x in signed fixed point and returns
// sign(x) * sqrt(sqrt(t^2 - L/a) - t), t = L/2 + 2/(pi*a), L = ln(1-x^2),
// saturating and flagging where the magnitude of x is one or more.
// ----------------------------------------------------------------------------
module inverse_error_function_unit #(
	parameter int IN_FRAC_BITS  = efi_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = efi_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] arg_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] result_value
	output logic [0:0]  m_axis_tuser    // [0] is_infinite
);

	localparam int MW = efi_pkg::META_W;
	localparam int TW = efi_pkg::T_W;
	localparam int SH_UP = (OUT_FRAC_BITS >= efi_pkg::SQRT_FRAC) ?
		OUT_FRAC_BITS - efi_pkg::SQRT_FRAC : 0;
	localparam int SH_DN = (OUT_FRAC_BITS < efi_pkg::SQRT_FRAC) ?
		efi_pkg::SQRT_FRAC - OUT_FRAC_BITS : 0;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX = 32'h8000_0000;

	logic en;
	logic ld;

	logic [32:0]          mag_c;
	logic [31:0]          m_c;
	efi_pkg::meta_t       meta_c;

	logic                 v_s1;
	logic [31:0]          m_s1;
	efi_pkg::meta_t       meta_s1;

	logic                 v_s2;
	logic [63:0]          u_s2;
	efi_pkg::meta_t       meta_s2;

	logic                       v_s35;
	logic [efi_pkg::NL_W-1:0]   nl_s35;
	logic [MW-1:0]              sb_s35;

	logic [64:0]                w_prod;
	logic                       v_s36;
	logic [efi_pkg::W_W-1:0]    w_s36;
	efi_pkg::meta_t             meta_s36;

	logic [63:0]                wa_prod;
	logic                       v_s37;
	logic signed [TW-1:0]       t_s37;
	logic [efi_pkg::WA_W-1:0]   wa_s37;
	efi_pkg::meta_t             meta_s37;

	logic [efi_pkg::TA_W-1:0]   ta_c;
	logic                       v_s38;
	logic [63:0]                tsq_s38;
	logic [63:0]                wash_s38;
	logic signed [TW-1:0]       t_s38;
	efi_pkg::meta_t             meta_s38;

	logic                       v_s39;
	logic [63:0]                s_s39;
	logic [MW+TW-1:0]           sb_s39;

	logic                       v_s71;
	logic [efi_pkg::ROOT_W-1:0] f_s71;
	logic [MW+TW-1:0]           sb_s71;
	efi_pkg::meta_t             meta_f;
	logic signed [TW-1:0]       t_f;

	logic signed [TW:0]         diff_c;
	logic [TW-1:0]              d_c;
	logic                       v_s72;
	logic [63:0]                x_s72;
	logic [MW-1:0]              meta_s72;

	logic                       v_s104;
	logic [efi_pkg::ROOT_W-1:0] r_s104;
	logic [MW-1:0]              sb_s104;
	efi_pkg::meta_t             meta_r;

	logic [31:0]          rmag_c;
	logic [31:0]          res_c;
	logic                 out_valid_q;
	logic [31:0]          result_q;
	logic                 inf_q;

	// Flow control: the output register takes a word when empty or drained;
	// the pipeline moves unless its last stage is full and cannot unload.
	assign ld = !out_valid_q || m_axis_tready;
	assign en = ld || !v_s104;
	assign s_axis_tready = en;

	// Decode: magnitude, rescale to Q0.32 and classify.
	always_comb begin
		mag_c = s_axis_tdata[31] ? (33'h1_0000_0000 - {1'b0, s_axis_tdata})
		                         : {1'b0, s_axis_tdata};
		if (IN_FRAC_BITS <= 32) begin
			m_c = 32'({31'd0, mag_c} << (32 - IN_FRAC_BITS));
		end else begin
			m_c = 32'({31'd0, mag_c} >> (IN_FRAC_BITS - 32));
		end
		meta_c.neg  = s_axis_tdata[31];
		meta_c.inf  = ({31'd0, mag_c} >= (64'd1 << IN_FRAC_BITS));
		meta_c.zero = (m_c == 32'd0);
	end

	// Stage 1: decoded argument.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
		end
	end

	// Stage 2: u = 1 - x^2 as Q0.64.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= m_c;
			meta_s1 <= meta_c;
			u_s2    <= 64'd0 - ({32'd0, m_s1} * {32'd0, m_s1});
			meta_s2 <= meta_s1;
		end
	end

	// Stages 3 to 35: -log2(u).
	efi_log2_pipe #(
		.SB_W (MW)
	) u_log2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_u      (u_s2),
		.in_sb     (meta_s2),
		.out_valid (v_s35),
		.out_nl    (nl_s35),
		.out_sb    (sb_s35)
	);

	// Stage 36: w = -ln(u) in Q.28.
	assign w_prod = {28'd0, nl_s35} * {37'd0, efi_pkg::LN2_Q28};

	// Stage 37: t and w/a.
	assign wa_prod = 64'({29'd0, w_s36} * {33'd0, efi_pkg::INV_A_Q28});

	// Stage 38: t squared and the shifted w/a term.
	assign ta_c = t_s37[TW-1] ? efi_pkg::TA_W'(-t_s37) : efi_pkg::TA_W'(t_s37);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s36 <= 1'b0;
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
			v_s39 <= 1'b0;
		end else if (en) begin
			v_s36 <= v_s35;
			v_s37 <= v_s36;
			v_s38 <= v_s37;
			v_s39 <= v_s38;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s36    <= w_prod[64:30];
			meta_s36 <= efi_pkg::meta_t'(sb_s35);
			t_s37    <= TW'(efi_pkg::K_Q28 - $signed({1'b0, w_s36[efi_pkg::W_W-1:1]}));
			wa_s37   <= wa_prod[63:28];
			meta_s37 <= meta_s36;
			tsq_s38  <= 64'({31'd0, ta_c} * {31'd0, ta_c});
			wash_s38 <= {wa_s37, 28'd0};
			t_s38    <= t_s37;
			meta_s38 <= meta_s37;
			s_s39    <= tsq_s38 + wash_s38;
			sb_s39   <= {meta_s38, t_s38};
		end
	end

	// Stages 40 to 71: f = sqrt(t^2 + w/a).
	efi_sqrt_pipe #(
		.SB_W (MW + TW)
	) u_sqrt_outer (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s39),
		.in_x      (s_s39),
		.in_sb     (sb_s39),
		.out_valid (v_s71),
		.out_root  (f_s71),
		.out_sb    (sb_s71)
	);

	// Stage 72: d = max(f - t, 0), scaled for the inner root.
	assign meta_f = efi_pkg::meta_t'(sb_s71[MW+TW-1:TW]);
	assign t_f    = $signed(sb_s71[TW-1:0]);
	assign diff_c = $signed({3'b000, f_s71}) - (TW+1)'(t_f);
	assign d_c    = diff_c[TW] ? '0 : diff_c[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s72 <= 1'b0;
		end else if (en) begin
			v_s72 <= v_s71;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s72    <= 64'({d_c, 30'd0});
			meta_s72 <= meta_f;
		end
	end

	// Stages 73 to 104: r = sqrt(d) in Q.29.
	efi_sqrt_pipe #(
		.SB_W (MW)
	) u_sqrt_inner (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s72),
		.in_x      (x_s72),
		.in_sb     (meta_s72),
		.out_valid (v_s104),
		.out_root  (r_s104),
		.out_sb    (sb_s104)
	);

	// Output scaling, saturation and sign.
	assign meta_r = efi_pkg::meta_t'(sb_s104);

	always_comb begin
		if (OUT_FRAC_BITS >= efi_pkg::SQRT_FRAC) begin
			rmag_c = (r_s104 > (POS_MAX >> SH_UP)) ? POS_MAX : (r_s104 << SH_UP);
		end else begin
			rmag_c = r_s104 >> SH_DN;
			if (rmag_c[31]) begin
				rmag_c = POS_MAX;
			end
		end
		if (meta_r.inf) begin
			res_c = meta_r.neg ? NEG_MAX : POS_MAX;
		end else if (meta_r.zero) begin
			res_c = 32'd0;
		end else begin
			res_c = meta_r.neg ? (32'd0 - rmag_c) : rmag_c;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= v_s104;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			result_q <= res_c;
			inf_q    <= meta_r.inf;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = result_q;
	assign m_axis_tuser[0] = inf_q;

	// A flagged result always sits at one of the two extremes.
	a_inf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
		(m_axis_tdata == POS_MAX || m_axis_tdata == NEG_MAX))
		else $error("flagged result is not saturated");

	// Input stalls only when the last stage and the output register are full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s104 && out_valid_q))
		else $error("input stalled without a full pipeline end");

	// A word leaving the pipeline while blocked must still be there next cycle.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s104 && !en) |=> v_s104)
		else $error("last pipeline stage dropped a word");

endmodule
